// ===== rtl/tak_pkg.sv =====
// Shared types, constants and tables for the tilt angle Kalman filter.
package tak_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic signed [31:0] DEG_SCALE = 32'sd3754937;
  localparam logic signed [31:0] BIAS_INIT = 32'sd3277;
  localparam logic signed [31:0] P00_INIT  = 32'sd16777;

  localparam logic [23:0] ANGLE_Q_RESET = 24'd167772;
  localparam logic [23:0] BIAS_Q_RESET  = 24'd5033;
  localparam logic [23:0] MEAS_R_RESET  = 24'd167772;

  localparam logic [1:0] REG_ANGLE_Q = 2'd0;
  localparam logic [1:0] REG_BIAS_Q  = 2'd1;
  localparam logic [1:0] REG_MEAS_R  = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [23:0] angle_q;
    logic [23:0] bias_q;
    logic [23:0] meas_r;
  } noise_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  // arctan(2^-i) in Q2.30
  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sh3243F6A8;
      5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;
      5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;
      5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;
      5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;
      5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;
      5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;
      5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;
      5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;
      5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;
      5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;
      5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;
      5'd23: v = 32'sh0000007F;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

  // fixed gyro offset per axis, Q16.16
  function automatic logic signed [24:0] gyro_offset(input logic [1:0] axis);
    logic signed [24:0] v;
    unique case (axis)
      2'd0:    v = -25'sd2575565;
      2'd1:    v = -25'sd5151130;
      2'd2:    v = 25'sd12019302;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = SAT_MAX;
    end else if (v < -68'sd2147483648) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tak_cordic.sv =====
// Vectoring CORDIC giving the accelerometer angle, one rotation per cycle.
module tak_cordic import tak_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] num,
  input  logic signed [15:0] den,
  output logic signed [31:0] z,
  output logic               done
);

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic [4:0]         i;
  logic               busy;
  logic signed [35:0] num_w;
  logic signed [35:0] den_w;
  logic signed [35:0] xs;
  logic signed [35:0] ys;

  assign num_w = {{4{num[15]}}, num, 16'b0};
  assign den_w = {{4{den[15]}}, den, 16'b0};
  assign xs    = x >>> i;
  assign ys    = y >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else if (start) begin
      i <= '0;
      z <= '0;
      if (num == 16'sd0 && den == 16'sd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
        x    <= den[15] ? -den_w : den_w;
        y    <= den[15] ? -num_w : num_w;
      end
    end else if (busy) begin
      if (!y[35]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_entry(i);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_entry(i);
      end
      i <= i + 5'd1;
      if (i == 5'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tak_div.sv =====
// Restoring divider for the Kalman gains: (num * 2^24) / den, saturated to 32 bits.
module tak_div import tak_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic signed [31:0] q,
  output logic               done
);

  logic [31:0] rem;
  logic [31:0] bits;
  logic [4:0]  cnt;
  logic        busy;
  logic        neg;
  logic        ovf;
  logic [31:0] mag;
  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  assign mag  = num[31] ? 32'd0 - num : num;
  assign t    = {rem, bits[31]};
  assign diff = t - {1'b0, den};
  assign ge   = t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      neg  <= num[31];
      rem  <= {8'b0, mag[31:8]};
      bits <= {mag[7:0], 24'b0};
      cnt  <= '0;
      // quotient of 2^32 or more: saturate at once
      if ({8'b0, mag[31:8]} >= den) begin
        ovf  <= 1'b1;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        ovf  <= 1'b0;
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      rem  <= ge ? diff[31:0] : t[31:0];
      bits <= {bits[30:0], ge};
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (ovf) begin
      q = neg ? SAT_MIN : SAT_MAX;
    end else if (neg) begin
      q = (bits > 32'h8000_0000) ? SAT_MIN : 32'd0 - bits;
    end else begin
      q = bits[31] ? SAT_MAX : bits;
    end
  end

endmodule

// ===== rtl/tak_lane.sv =====
// One axis: two-state Kalman filter sequencer around a shared multiplier.
module tak_lane import tak_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         ctrl,
  input  logic signed [15:0] num,
  input  logic signed [15:0] den,
  input  logic signed [15:0] rate,
  input  logic [19:0]        dt,
  input  logic               reinit,
  input  logic signed [24:0] offset,
  input  noise_t             noise,
  output lane_stat_t         stat,
  output logic signed [31:0] angle
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRED  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SCALE = 6'b001000,
    S_CORR  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic   phase;
  logic [2:0] op;
  logic   div_go;

  logic signed [31:0] angle_est, bias, p00, p01, p10, p11, k0, k1, yv;
  logic signed [15:0] rate_q;
  logic [19:0]        dt_q;
  logic signed [66:0] prod;

  logic signed [34:0] ma;
  logic signed [31:0] mb;
  logic signed [31:0] base;
  logic               sub;
  logic [4:0]         sh;
  logic signed [66:0] rsum;
  logic signed [66:0] rshift;
  logic signed [67:0] wres;
  logic signed [31:0] wsat;
  logic signed [31:0] ysat;

  logic signed [31:0] cz;
  logic               cdone;
  logic signed [32:0] s_sum;
  logic               s_pos;
  logic               div_start;
  logic signed [31:0] q0, q1;
  logic               d0done, d1done;

  function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  tak_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start && state == S_IDLE),
    .num   (num),
    .den   (den),
    .z     (cz),
    .done  (cdone)
  );

  assign s_sum     = {p00[31], p00} + {9'b0, noise.meas_r};
  assign s_pos     = !s_sum[32] && (s_sum != 33'sd0);
  assign div_start = (state == S_DIV) && div_go && s_pos;

  tak_div u_div_k0 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p00),
    .den   (s_sum[31:0]),
    .q     (q0),
    .done  (d0done)
  );

  tak_div u_div_k1 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p10),
    .den   (s_sum[31:0]),
    .q     (q1),
    .done  (d1done)
  );

  // operand selection for the shared multiplier and the write-back step
  always_comb begin
    ma   = '0;
    mb   = '0;
    base = '0;
    sub  = 1'b0;
    sh   = 5'd24;
    unique case (state)
      S_PRED: begin
        sh = 5'd16;
        mb = {12'b0, dt_q};
        unique case (op)
          3'd0: begin
            ma   = {{3{rate_q[15]}}, rate_q, 16'b0} + {{10{offset[24]}}, offset} - sx35(bias);
            base = angle_est;
          end
          3'd1: begin
            ma   = {11'b0, noise.angle_q} - sx35(p01) - sx35(p10);
            base = p00;
          end
          3'd2: begin
            ma   = sx35(p11);
            base = p01;
            sub  = 1'b1;
          end
          3'd3: begin
            ma   = sx35(p11);
            base = p10;
            sub  = 1'b1;
          end
          default: begin
            ma   = {11'b0, noise.bias_q};
            base = p11;
          end
        endcase
      end
      S_SCALE: begin
        sh = 5'd30;
        ma = sx35(cz);
        mb = DEG_SCALE;
      end
      S_CORR: begin
        // each covariance term reads predicted values not yet overwritten
        unique case (op)
          3'd0: begin ma = sx35(k1); mb = p01; base = p11; sub = 1'b1; end
          3'd1: begin ma = sx35(k0); mb = p01; base = p01; sub = 1'b1; end
          3'd2: begin ma = sx35(k1); mb = p00; base = p10; sub = 1'b1; end
          3'd3: begin ma = sx35(k0); mb = p00; base = p00; sub = 1'b1; end
          3'd4: begin ma = sx35(k0); mb = yv;  base = angle_est; end
          default: begin ma = sx35(k1); mb = yv; base = bias; end
        endcase
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  assign rsum   = prod + (67'sd1 <<< (sh - 5'd1));
  assign rshift = rsum >>> sh;
  assign wres   = sub ? {{36{base[31]}}, base} - {rshift[66], rshift}
                      : {{36{base[31]}}, base} + {rshift[66], rshift};
  assign wsat   = sat32(wres);
  assign ysat   = sat32({rshift[66], rshift} - {{36{angle_est[31]}}, angle_est});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      op        <= '0;
      div_go    <= 1'b0;
      angle_est <= '0;
      bias      <= BIAS_INIT;
      p00       <= P00_INIT;
      p01       <= '0;
      p10       <= '0;
      p11       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            rate_q <= rate;
            dt_q   <= dt;
            op     <= '0;
            phase  <= 1'b0;
            state  <= S_PRED;
            if (reinit) begin
              bias <= BIAS_INIT;
              p00  <= P00_INIT;
              p01  <= '0;
              p10  <= '0;
              p11  <= '0;
            end
          end
        end
        S_PRED: begin
          if (!phase) begin
            prod  <= ma * mb;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            op    <= op + 3'd1;
            unique case (op)
              3'd0:    angle_est <= wsat;
              3'd1:    p00       <= wsat;
              3'd2:    p01       <= wsat;
              3'd3:    p10       <= wsat;
              default: p11       <= wsat;
            endcase
            if (op == 3'd4) begin
              state  <= S_DIV;
              div_go <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_go) begin
            div_go <= 1'b0;
            if (!s_pos) begin
              // no gain: correction leaves the estimate alone
              k0    <= '0;
              k1    <= '0;
              state <= S_SCALE;
            end
          end else if (d0done && d1done) begin
            k0    <= q0;
            k1    <= q1;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (!phase) begin
            if (cdone) begin
              prod  <= ma * mb;
              phase <= 1'b1;
            end
          end else begin
            yv    <= ysat;
            phase <= 1'b0;
            op    <= '0;
            state <= S_CORR;
          end
        end
        S_CORR: begin
          if (!phase) begin
            prod  <= ma * mb;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            op    <= op + 3'd1;
            unique case (op)
              3'd0:    p11       <= wsat;
              3'd1:    p01       <= wsat;
              3'd2:    p10       <= wsat;
              3'd3:    p00       <= wsat;
              3'd4:    angle_est <= wsat;
              default: bias      <= wsat;
            endcase
            if (op == 3'd5) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign angle     = angle_est;

endmodule

// ===== rtl/tilt_angle_kalman_filter.sv =====
// Three-axis tilt estimator: per-axis Kalman lanes and an output merge register.
// An input transaction passes through prediction, a divider start, the divide steps, a gain load,
// the angle scale, the correction and the merge register before out_valid rises.
// A new transaction is taken only when every lane is idle; the sequence is shorter when every
// lane skips the divide on a non-positive S, and a stalled output holds the lanes.
// Synchronous active-high reset restores noise registers, angles, biases and covariance.
module tilt_angle_kalman_filter import tak_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic [19:0]        time_step,
  input  logic               reinit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_x,
  output logic signed [31:0] angle_y,
  output logic signed [31:0] angle_z,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  noise_t             noise;
  lane_ctrl_t         ctrl;
  lane_stat_t         stat [3];
  logic signed [31:0] lane_angle [3];
  logic signed [15:0] accel [3];
  logic signed [15:0] rate [3];
  logic               all_done;
  logic               load;

  assign accel[0] = accel_x;
  assign accel[1] = accel_y;
  assign accel[2] = accel_z;
  assign rate[0]  = rate_x;
  assign rate[1]  = rate_y;
  assign rate[2]  = rate_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise.angle_q <= ANGLE_Q_RESET;
      noise.bias_q  <= BIAS_Q_RESET;
      noise.meas_r  <= MEAS_R_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_ANGLE_Q) noise.angle_q <= cfg_data;
      if (cfg_index == REG_BIAS_Q)  noise.bias_q  <= cfg_data;
      if (cfg_index == REG_MEAS_R)  noise.meas_r  <= cfg_data;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    if (a < AXES) begin : g_on
      tak_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .num    (accel[(a + 1) % 3]),
        .den    (accel[(a + 2) % 3]),
        .rate   (rate[a]),
        .dt     (time_step),
        .reinit (reinit),
        .offset (gyro_offset(2'(a))),
        .noise  (noise),
        .stat   (stat[a]),
        .angle  (lane_angle[a])
      );
    end else begin : g_off
      assign stat[a].idle  = 1'b1;
      assign stat[a].done  = 1'b1;
      assign lane_angle[a] = '0;
    end
  end

  assign in_ready   = stat[0].idle & stat[1].idle & stat[2].idle;
  assign all_done   = stat[0].done & stat[1].done & stat[2].done;
  assign load       = all_done && (!out_valid || out_ready);
  assign ctrl.start = in_valid && in_ready;
  assign ctrl.ack   = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_x <= lane_angle[0];
      angle_y <= lane_angle[1];
      angle_z <= lane_angle[2];
    end
  end

endmodule
